FILE: rtl/mtr_pkg.sv
// Package: shared types, constants and tables of the Metropolis spin update core.
`default_nettype none
package mtr_pkg;

  localparam int MAX_SITES = 4096;
  localparam int MAX_DIMS  = 10;
  localparam int ADDR_W    = $clog2(MAX_SITES);

  localparam logic [12:0] ACCEPT_MAX = 13'd8191;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  // 33 * ln2 in Q32: at or above this de/T gives a probability of zero
  localparam logic [36:0] EXP_CUT    = 37'd98242467576;
  localparam logic [3:0]  EXP_TERMS  = 4'd12;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_DIMS = 2'd0,
    CFG_SIDE = 2'd1,
    CFG_TEMP = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_DISPATCH,
    S_RDW,
    S_DIGIT,
    S_NBR,
    S_NWAIT,
    S_ENERGY,
    S_WAIT,
    S_FINISH,
    S_DONE
  } core_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_RANGE,
    A_LN,
    A_MUL,
    A_REC,
    A_FIX,
    A_DONE
  } acc_state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        site_index;
    logic               spin_in;
    logic signed [15:0] field_in;
    logic [31:0]        random_value;
  } in_word_t;

  typedef struct packed {
    logic [11:0]        visited_site;
    logic               spin_out;
    logic signed [15:0] field_out;
    logic               flipped;
    logic               last_of_sweep;
    logic [12:0]        sweep_accepts;
    logic               config_error;
  } out_word_t;

  typedef struct packed {
    logic done;
    logic accept;
  } acc_res_t;

  // floor(2^32 / k) for the Horner divide by k
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] v;
    case (k)
      4'd1:    v = 33'd4294967296;
      4'd2:    v = 33'd2147483648;
      4'd3:    v = 33'd1431655765;
      4'd4:    v = 33'd1073741824;
      4'd5:    v = 33'd858993459;
      4'd6:    v = 33'd715827882;
      4'd7:    v = 33'd613566756;
      4'd8:    v = 33'd536870912;
      4'd9:    v = 33'd477218588;
      4'd10:   v = 33'd429496729;
      4'd11:   v = 33'd390451572;
      4'd12:   v = 33'd357913941;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/metropolis_lattice_spin_update_core.sv
// Top level: Metropolis single-spin update engine over a periodic hypercube lattice.
// A step whose flip is certain skips the acceptance test (serial de/T divide, ln2 split,
// 12-term Horner series); the test ends early when de/T is past the exp cutoff.
// One word in work at a time; the next is taken in the cycle after the result is registered.
// Reset (rst, synchronous) restores the state, configuration, output valid and sweep state; the stores keep data.
`default_nettype none
module metropolis_lattice_spin_update_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire mtr_pkg::in_word_t   in_word,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      mtr_pkg::out_word_t  out_word,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  // configuration registers
  logic [3:0]  dimensions;
  logic [6:0]  side_length;
  logic [15:0] temperature;

  // sweep state
  logic [11:0] sweep_position;
  logic [12:0] accept_count;

  mtr_pkg::core_state_t state, state_next;
  mtr_pkg::in_word_t    item;
  mtr_pkg::out_word_t   res;
  mtr_pkg::out_word_t   res_init;

  // lattice size pass: stride table and site count
  logic [3:0]  d_cnt;
  logic [12:0] st;
  logic [19:0] st_mul;
  logic        err;
  logic [12:0] n_sites;
  logic        size_bad, size_over, size_end;
  logic [11:0] stride [mtr_pkg::MAX_DIMS];
  logic [5:0]  coord  [mtr_pkg::MAX_DIMS];

  // digit extraction: one restoring divide by side_length per dimension
  logic [11:0] quo;
  logic [6:0]  rem;
  logic [3:0]  bcnt;
  logic [11:0] site;
  logic [7:0]  trial;
  logic        trial_ge;
  logic [5:0]  dig_coord;
  logic [17:0] dig_prod;
  logic        stale;

  // neighbor scan
  logic [4:0]         nk;
  logic               pend;
  logic signed [5:0]  nbr;
  logic [3:0]         nb_d;
  logic [5:0]         nb_c;
  logic [11:0]        nb_s;
  logic [18:0]        span_full;
  logic [11:0]        span;
  logic [11:0]        minus_a, plus_a;
  logic               self_k;

  // energy and decision
  logic               spin_cur;
  logic signed [15:0] field_cur;
  logic signed [18:0] de;
  logic signed [18:0] h;
  logic signed [18:0] h2;
  logic               de_pos;
  logic               flip;
  logic               acc_start;
  mtr_pkg::acc_res_t  acc_res;
  logic [12:0]        acc_new;
  logic [12:0]        pos1;
  logic               last;

  // stores
  logic                              spin_mem  [mtr_pkg::MAX_SITES];
  logic [15:0]                       field_mem [mtr_pkg::MAX_SITES];
  logic                              spin_rd;
  logic [15:0]                       field_rd;
  logic [mtr_pkg::ADDR_W-1:0]        rd_addr, wr_addr;
  logic                              spin_we, field_we, spin_wd;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != mtr_pkg::S_IDLE);

  always_comb begin
    size_bad  = (dimensions == 4'd0) || (dimensions > 4'(mtr_pkg::MAX_DIMS)) ||
                (side_length < 7'd2);
    st_mul    = {7'd0, st} * {13'd0, side_length};
    size_over = st_mul > 20'(mtr_pkg::MAX_SITES);
    size_end  = size_bad || (d_cnt == dimensions) || size_over;
    stale     = {1'b0, sweep_position} >= n_sites;

    // result word as known at dispatch; a stale step on a valid lattice starts a new sweep
    res_init               = '0;
    res_init.sweep_accepts = (item.op == mtr_pkg::OP_STEP && stale && !err) ? 13'd0
                                                                            : accept_count;
    res_init.config_error  = err;
    if (item.op == mtr_pkg::OP_LOAD) begin
      res_init.visited_site = item.site_index;
      res_init.spin_out     = item.spin_in;
      res_init.field_out    = item.field_in;
    end

    trial     = {rem, quo[11]};
    trial_ge  = trial >= {1'b0, side_length};
    dig_coord = (rem == 7'd0) ? 6'(side_length - 7'd1) : 6'(rem - 7'd1);
    dig_prod  = dig_coord * stride[d_cnt];

    nb_d      = (nk[4:1] < 4'(mtr_pkg::MAX_DIMS)) ? nk[4:1] : 4'd0;
    nb_c      = coord[nb_d];
    nb_s      = stride[nb_d];
    span_full = (side_length - 7'd1) * nb_s;
    span      = span_full[11:0];
    minus_a   = (nb_c == 6'd0) ? site + span : site - nb_s;
    plus_a    = ({1'b0, nb_c} == side_length - 7'd1) ? site - span : site + nb_s;
    self_k    = (nk == {dimensions, 1'b0});

    h  = {{5{nbr[5]}}, nbr, 8'h00} + {{3{field_rd[15]}}, field_rd};
    h2 = {h[17:0], 1'b0};
    de_pos = !de[18] && (de != 19'sd0);

    acc_new = (flip && accept_count < mtr_pkg::ACCEPT_MAX) ? accept_count + 13'd1
                                                           : accept_count;
    pos1    = {1'b0, sweep_position} + 13'd1;
    last    = pos1 >= n_sites;
  end

  // next state and store controls
  always_comb begin
    state_next = state;
    acc_start  = 1'b0;
    spin_we    = 1'b0;
    field_we   = 1'b0;
    spin_wd    = item.spin_in;
    wr_addr    = item.site_index;
    rd_addr    = site;
    unique case (state)
      mtr_pkg::S_IDLE: if (in_valid) state_next = mtr_pkg::S_SIZE;
      mtr_pkg::S_SIZE: if (size_end) state_next = mtr_pkg::S_DISPATCH;
      mtr_pkg::S_DISPATCH: begin
        case (item.op)
          mtr_pkg::OP_LOAD: begin
            spin_we    = 1'b1;
            field_we   = 1'b1;
            state_next = mtr_pkg::S_DONE;
          end
          mtr_pkg::OP_READ: begin
            rd_addr    = item.site_index;
            state_next = mtr_pkg::S_RDW;
          end
          mtr_pkg::OP_STEP: state_next = err ? mtr_pkg::S_DONE : mtr_pkg::S_DIGIT;
          default:          state_next = mtr_pkg::S_IDLE;
        endcase
      end
      mtr_pkg::S_RDW: state_next = mtr_pkg::S_DONE;
      mtr_pkg::S_DIGIT: begin
        if (bcnt == 4'd12 && d_cnt == dimensions - 4'd1) state_next = mtr_pkg::S_NBR;
      end
      mtr_pkg::S_NBR: begin
        rd_addr = self_k ? site : (nk[0] ? plus_a : minus_a);
        if (self_k) state_next = mtr_pkg::S_NWAIT;
      end
      mtr_pkg::S_NWAIT: state_next = mtr_pkg::S_ENERGY;
      mtr_pkg::S_ENERGY: begin
        acc_start  = de_pos;
        state_next = de_pos ? mtr_pkg::S_WAIT : mtr_pkg::S_FINISH;
      end
      mtr_pkg::S_WAIT: if (acc_res.done) state_next = mtr_pkg::S_FINISH;
      mtr_pkg::S_FINISH: begin
        spin_we    = flip;
        spin_wd    = ~spin_cur;
        wr_addr    = site;
        state_next = mtr_pkg::S_DONE;
      end
      mtr_pkg::S_DONE: if (!out_valid || !out_stall) state_next = mtr_pkg::S_IDLE;
      default: state_next = mtr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // lattice stores, registered read
  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[wr_addr] <= spin_wd;
    if (field_we) field_mem[wr_addr] <= item.field_in;
    spin_rd  <= spin_mem[rd_addr];
    field_rd <= field_mem[rd_addr];
  end

  // configuration and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions     <= 4'd2;
      side_length    <= 7'd64;
      temperature    <= 16'd256;
      sweep_position <= '0;
      accept_count   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mtr_pkg::CFG_DIMS: dimensions  <= cfg_data[3:0];
          mtr_pkg::CFG_SIDE: side_length <= cfg_data[6:0];
          mtr_pkg::CFG_TEMP: temperature <= cfg_data;
          default: ;
        endcase
      end
      // a position left over from a larger lattice restarts the sweep
      if (state == mtr_pkg::S_DISPATCH && item.op == mtr_pkg::OP_STEP && !err && stale) begin
        sweep_position <= '0;
        accept_count   <= '0;
      end
      if (state == mtr_pkg::S_FINISH) begin
        sweep_position <= last ? 12'd0 : pos1[11:0];
        accept_count   <= last ? 13'd0 : acc_new;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mtr_pkg::S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == mtr_pkg::S_DONE && (!out_valid || !out_stall)) begin
      out_word <= res;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mtr_pkg::S_IDLE: begin
        item  <= in_word;
        d_cnt <= '0;
        st    <= 13'd1;
        err   <= 1'b0;
      end
      mtr_pkg::S_SIZE: begin
        if (size_bad) begin
          err <= 1'b1;
        end else if (d_cnt == dimensions) begin
          n_sites <= st;
        end else begin
          stride[d_cnt] <= st[11:0];
          st            <= st_mul[12:0];
          d_cnt         <= d_cnt + 4'd1;
          if (size_over) err <= 1'b1;
        end
      end
      mtr_pkg::S_DISPATCH: begin
        res   <= res_init;
        quo   <= stale ? 12'd0 : sweep_position;
        rem   <= '0;
        bcnt  <= '0;
        d_cnt <= '0;
        site  <= '0;
      end
      mtr_pkg::S_RDW: begin
        res.visited_site <= item.site_index;
        res.spin_out     <= spin_rd;
        res.field_out    <= field_rd;
      end
      mtr_pkg::S_DIGIT: begin
        if (bcnt != 4'd12) begin
          rem  <= trial_ge ? 7'(trial - {1'b0, side_length}) : trial[6:0];
          quo  <= {quo[10:0], trial_ge};
          bcnt <= bcnt + 4'd1;
        end else begin
          coord[d_cnt] <= dig_coord;
          site         <= site + dig_prod[11:0];
          d_cnt        <= d_cnt + 4'd1;
          rem          <= '0;
          bcnt         <= '0;
          nk           <= '0;
          pend         <= 1'b0;
          nbr          <= '0;
        end
      end
      mtr_pkg::S_NBR: begin
        pend <= !self_k;
        nk   <= nk + 5'd1;
        if (pend) nbr <= spin_rd ? nbr + 6'sd1 : nbr - 6'sd1;
      end
      mtr_pkg::S_NWAIT: begin
        spin_cur  <= spin_rd;
        field_cur <= field_rd;
        de        <= spin_rd ? h2 : -h2;
      end
      mtr_pkg::S_ENERGY: flip <= !de_pos;
      mtr_pkg::S_WAIT: if (acc_res.done) flip <= acc_res.accept;
      mtr_pkg::S_FINISH: begin
        res.visited_site  <= site;
        res.spin_out      <= spin_cur ^ flip;
        res.field_out     <= field_cur;
        res.flipped       <= flip;
        res.last_of_sweep <= last;
        res.sweep_accepts <= acc_new;
        res.config_error  <= 1'b0;
      end
      default: ;
    endcase
  end

  mtr_accept u_accept (
    .clk          (clk),
    .rst          (rst),
    .start        (acc_start),
    .de           (de[16:0]),
    .temperature  (temperature),
    .random_value (item.random_value),
    .res          (acc_res)
  );

endmodule
`default_nettype wire

FILE: rtl/mtr_accept.sv
// Acceptance unit: serial de/T divide, ln2 range split, Horner exp series, compare.
`default_nettype none
module mtr_accept (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [16:0]      de,
  input  wire logic [15:0]      temperature,
  input  wire logic [31:0]      random_value,
  output mtr_pkg::acc_res_t     res
);

  mtr_pkg::acc_state_t state, state_next;

  logic [15:0] rem;
  logic [48:0] quo;
  logic [5:0]  cnt;
  logic [36:0] xr;
  logic [5:0]  nq;
  logic [2:0]  lb;
  logic [32:0] p;
  logic [3:0]  k;
  logic [64:0] prod;
  logic [31:0] t;
  logic [64:0] prod2;

  logic [16:0] trial;
  logic        trial_ge;
  logic [36:0] cand;
  logic [31:0] q0;
  logic [35:0] qk;
  logic [35:0] diff;
  logic [32:0] q;
  logic [32:0] prob;

  always_comb begin
    trial    = {rem, quo[48]};
    trial_ge = trial >= {1'b0, temperature};
    cand     = {5'd0, mtr_pkg::LN2_Q32} << lb;
    q0       = prod2[63:32];
    qk       = q0 * {32'd0, k};
    diff     = {4'd0, t} - qk;
    q        = (diff >= {32'd0, k}) ? {1'b0, q0} + 33'd1 : {1'b0, q0};
    prob     = p >> nq;
  end

  always_comb begin
    state_next = state;
    res.done   = 1'b0;
    res.accept = 1'b0;
    unique case (state)
      mtr_pkg::A_IDLE: begin
        if (start) begin
          state_next = (temperature == 16'd0) ? mtr_pkg::A_DONE : mtr_pkg::A_DIV;
        end
      end
      mtr_pkg::A_DIV:   if (cnt == 6'd48) state_next = mtr_pkg::A_RANGE;
      mtr_pkg::A_RANGE: begin
        state_next = (quo >= {12'd0, mtr_pkg::EXP_CUT}) ? mtr_pkg::A_DONE : mtr_pkg::A_LN;
      end
      mtr_pkg::A_LN:    if (lb == 3'd0) state_next = mtr_pkg::A_MUL;
      mtr_pkg::A_MUL:   state_next = mtr_pkg::A_REC;
      mtr_pkg::A_REC:   state_next = mtr_pkg::A_FIX;
      mtr_pkg::A_FIX:   state_next = (k == 4'd1) ? mtr_pkg::A_DONE : mtr_pkg::A_MUL;
      mtr_pkg::A_DONE: begin
        res.done   = 1'b1;
        res.accept = {1'b0, random_value} < prob;
        state_next = mtr_pkg::A_IDLE;
      end
      default: state_next = mtr_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtr_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mtr_pkg::A_IDLE: begin
        rem <= '0;
        quo <= {de, 32'd0};
        cnt <= '0;
        p   <= '0;
        nq  <= '0;
      end
      mtr_pkg::A_DIV: begin
        if (trial_ge) begin
          rem <= 16'(trial - {1'b0, temperature});
        end else begin
          rem <= trial[15:0];
        end
        quo <= {quo[47:0], trial_ge};
        cnt <= cnt + 6'd1;
      end
      mtr_pkg::A_RANGE: begin
        xr <= quo[36:0];
        nq <= '0;
        lb <= 3'd5;
        p  <= '0;
      end
      mtr_pkg::A_LN: begin
        if (xr >= cand) begin
          xr     <= xr - cand;
          nq[lb] <= 1'b1;
        end
        lb <= lb - 3'd1;
        p  <= 33'h1_0000_0000;
        k  <= mtr_pkg::EXP_TERMS;
      end
      mtr_pkg::A_MUL: prod <= xr[31:0] * p;
      mtr_pkg::A_REC: begin
        t     <= prod[63:32];
        prod2 <= prod[63:32] * mtr_pkg::recip(k);
      end
      mtr_pkg::A_FIX: begin
        p <= 33'h1_0000_0000 - q;
        k <= k - 4'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
